[src/prf_pkg.sv]
package prf_pkg;

    // Sequencer state codes
    localparam int STATE_BITS = 4;
    localparam logic [STATE_BITS-1:0] S_IDLE = 4'd0;
    localparam logic [STATE_BITS-1:0] S_DIV  = 4'd1;
    localparam logic [STATE_BITS-1:0] S_TCHK = 4'd2;
    localparam logic [STATE_BITS-1:0] S_TAIL = 4'd3;
    localparam logic [STATE_BITS-1:0] S_CAND = 4'd4;
    localparam logic [STATE_BITS-1:0] S_ECHK = 4'd5;
    localparam logic [STATE_BITS-1:0] S_MUL  = 4'd6;
    localparam logic [STATE_BITS-1:0] S_PCHK = 4'd7;
    localparam logic [STATE_BITS-1:0] S_OUT  = 4'd8;

    // Where a finished division hands over
    localparam logic RET_TRIAL = 1'b0;
    localparam logic RET_EXP   = 1'b1;

endpackage

[src/prf_alu.sv]
module prf_alu #(
    parameter int W = 31
) (
    input  logic [W:0]   a,
    input  logic [W-1:0] b,
    output logic [W-1:0] res,
    output logic         ge
);

    logic [W:0] diff;

    // Compare and conditional subtract: one restoring step or one modular reduction.
    always_comb
    begin
        diff = a - {1'b0, b};
        ge   = (a >= {1'b0, b});
        res  = ge ? diff[W-1:0] : a[W-1:0];
    end

endmodule

[src/primitive_root_finder_core.sv]
// Smallest primitive root finder.
// The slave stream takes one modulus per transfer; the master stream returns one
// result per modulus: the root in tdata and the found flag in tuser.
// Each modulus is handled by a sequencer driving one shared compare-and-subtract
// unit. The factor search of m-1 runs a bit-serial restoring division per trial
// divisor, up to about sqrt(m) divisors. Each candidate then needs, per stored
// factor, up to one division plus a square-and-multiply power. A modulus below
// two skips the search and returns root zero with the found flag clear.
// s_axis_tready is high only while the sequencer is idle. A finished result is
// held in an output register; the next modulus may be taken while it waits, and a
// later result waits in the sequencer until the receiver takes the earlier one.
// Reset empties the output register and returns the sequencer to idle.
module primitive_root_finder_core
    import prf_pkg::*;
#(
    parameter int VALUE_BITS  = 31,
    parameter int MAX_FACTORS = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // modulus in bits VALUE_BITS-1:0, zeros above
    input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // root in bits VALUE_BITS-1:0, zeros above
    output logic [((VALUE_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // found
    output logic                                  m_axis_tuser
);

    localparam int W   = VALUE_BITS;
    localparam int DW  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CW  = $clog2(VALUE_BITS);
    localparam int FIW = $clog2(MAX_FACTORS);
    localparam int FCW = $clog2(MAX_FACTORS + 1);

    logic [STATE_BITS-1:0] state_reg, state_next;
    logic [W-1:0] m_reg, m_next, phi_reg, phi_next, n_reg, n_next, k_reg, k_next;
    logic [W-1:0] q_reg, q_next, rm_reg, rm_next, dv_reg, dv_next;
    logic [W-1:0] acc_reg, acc_next, ma_reg, ma_next, mb_reg, mb_next;
    logic [W-1:0] pow_reg, pow_next, base_reg, base_next, e_reg, e_next;
    logic [W:0]   cand_reg, cand_next;
    logic [CW-1:0] cnt_reg, cnt_next, ebit_reg, ebit_next;
    logic [FCW-1:0] fcnt_reg, fcnt_next;
    logic [FIW-1:0] fidx_reg, fidx_next;
    logic inner_reg, inner_next, ret_reg, ret_next, phase_reg, phase_next;
    logic mulb_reg, mulb_next;
    logic [W-1:0] res_root_reg, res_root_next;
    logic res_found_reg, res_found_next;
    logic ovalid_reg, ovalid_next;
    logic [W-1:0] root_reg, root_next;
    logic found_reg, found_next;
    logic [W-1:0] fac_mem [MAX_FACTORS];
    logic         fac_we;
    logic [W-1:0] fac_wdata;
    logic [W-1:0] fac_rd_reg;

    logic [W:0]   alu_a;
    logic [W-1:0] alu_b, alu_res;
    logic         alu_ge;
    logic [W-1:0] in_m;

    prf_alu #(.W(W)) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    assign in_m          = s_axis_tdata[W-1:0];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = DW'(root_reg);
    assign m_axis_tuser  = found_reg;

    // Operand selection for the shared unit. A division of the exponent takes its
    // divisor straight from the registered factor read.
    always_comb
    begin
        alu_a = {rm_reg, q_reg[W-1]};
        alu_b = (ret_reg == RET_EXP) ? fac_rd_reg : dv_reg;
        if (state_reg == S_MUL)
        begin
            alu_b = m_reg;
            if (!phase_reg)
                alu_a = {acc_reg, 1'b0};
            else
                alu_a = {1'b0, acc_reg} + {1'b0, ma_reg};
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        m_next = m_reg; phi_next = phi_reg; n_next = n_reg; k_next = k_reg;
        q_next = q_reg; rm_next = rm_reg; dv_next = dv_reg;
        acc_next = acc_reg; ma_next = ma_reg; mb_next = mb_reg;
        pow_next = pow_reg; base_next = base_reg; e_next = e_reg;
        cand_next = cand_reg; cnt_next = cnt_reg; ebit_next = ebit_reg;
        fcnt_next = fcnt_reg; fidx_next = fidx_reg;
        inner_next = inner_reg; ret_next = ret_reg; phase_next = phase_reg;
        mulb_next = mulb_reg;
        res_root_next = res_root_reg; res_found_next = res_found_reg;
        ovalid_next = ovalid_reg; root_next = root_reg; found_next = found_reg;
        fac_we = 1'b0;
        fac_wdata = n_reg;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    m_next = in_m;
                    if (in_m < W'(2))
                    begin
                        res_root_next  = '0;
                        res_found_next = 1'b0;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        phi_next   = in_m - W'(1);
                        n_next     = in_m - W'(1);
                        k_next     = W'(2);
                        fcnt_next  = '0;
                        inner_next = 1'b0;
                        q_next     = in_m - W'(1);
                        rm_next    = '0;
                        dv_next    = W'(2);
                        cnt_next   = CW'(W - 1);
                        ret_next   = RET_TRIAL;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rm_next = alu_res;
                q_next  = {q_reg[W-2:0], alu_ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                    state_next = (ret_reg == RET_TRIAL) ? S_TCHK : S_ECHK;
            end
            S_TCHK:
            begin
                // Decide on the next trial division.
                rm_next  = '0;
                cnt_next = CW'(W - 1);
                state_next = S_DIV;
                if (inner_reg)
                begin
                    if (rm_reg == '0)
                    begin
                        n_next = q_reg;
                    end
                    else
                    begin
                        inner_next = 1'b0;
                        k_next = k_reg + W'(1);
                        dv_next = k_reg + W'(1);
                        q_next = n_reg;
                    end
                end
                else if (k_reg > q_reg)
                begin
                    state_next = S_TAIL;
                end
                else if (rm_reg == '0)
                begin
                    if (fcnt_reg < FCW'(MAX_FACTORS))
                    begin
                        fac_we = 1'b1;
                        fac_wdata = k_reg;
                        fcnt_next = fcnt_reg + FCW'(1);
                    end
                    inner_next = 1'b1;
                    n_next = q_reg;
                end
                else
                begin
                    k_next = k_reg + W'(1);
                    dv_next = k_reg + W'(1);
                    q_next = n_reg;
                end
            end
            S_TAIL:
            begin
                if (n_reg > W'(1) && fcnt_reg < FCW'(MAX_FACTORS))
                begin
                    fac_we = 1'b1;
                    fac_wdata = n_reg;
                    fcnt_next = fcnt_reg + FCW'(1);
                end
                cand_next  = (W+1)'(2);
                state_next = S_CAND;
            end
            S_CAND:
            begin
                fidx_next = '0;
                if (cand_reg > {1'b0, m_reg})
                begin
                    res_root_next  = '0;
                    res_found_next = 1'b0;
                    state_next     = S_OUT;
                end
                else if (fcnt_reg == '0)
                begin
                    res_root_next  = cand_reg[W-1:0];
                    res_found_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    q_next = phi_reg; rm_next = '0;
                    cnt_next = CW'(W - 1); ret_next = RET_EXP;
                    state_next = S_DIV;
                end
            end
            S_ECHK:
            begin
                // Start the power with the quotient as exponent.
                e_next    = q_reg;
                pow_next  = W'(1);
                base_next = (cand_reg == {1'b0, m_reg}) ? '0 : cand_reg[W-1:0];
                ebit_next = CW'(W - 1);
                ma_next = W'(1); mb_next = W'(1); acc_next = '0;
                cnt_next = CW'(W - 1); phase_next = 1'b0; mulb_next = 1'b0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // Shift-add modular product, MSB first, reduce after each add.
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    acc_next = alu_res;
                end
                else
                begin
                    if (mb_reg[W-1])
                        acc_next = alu_res;
                    mb_next  = {mb_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == '0)
                    begin
                        pow_next = mb_reg[W-1] ? alu_res : acc_reg;
                        acc_next = '0;
                        cnt_next = CW'(W - 1);
                        ma_next  = mb_reg[W-1] ? alu_res : acc_reg;
                        if (!mulb_reg && e_reg[ebit_reg])
                        begin
                            mulb_next = 1'b1;
                            mb_next   = base_reg;
                        end
                        else if (ebit_reg == '0)
                        begin
                            state_next = S_PCHK;
                        end
                        else
                        begin
                            mulb_next = 1'b0;
                            ebit_next = ebit_reg - CW'(1);
                            mb_next   = mb_reg[W-1] ? alu_res : acc_reg;
                        end
                    end
                end
            end
            S_PCHK:
            begin
                if (pow_reg == W'(1))
                begin
                    cand_next  = cand_reg + (W+1)'(1);
                    state_next = S_CAND;
                end
                else if (FCW'(fidx_reg) + FCW'(1) == fcnt_reg)
                begin
                    res_root_next  = cand_reg[W-1:0];
                    res_found_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    fidx_next = fidx_reg + FIW'(1);
                    q_next = phi_reg; rm_next = '0;
                    cnt_next = CW'(W - 1); ret_next = RET_EXP;
                    state_next = S_DIV;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    root_next   = res_root_reg;
                    found_next  = res_found_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            fcnt_reg   <= '0;
            cnt_reg    <= '0;
            ebit_reg   <= '0;
            fidx_reg   <= '0;
            inner_reg  <= 1'b0;
            ret_reg    <= RET_TRIAL;
            phase_reg  <= 1'b0;
            mulb_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            fcnt_reg   <= fcnt_next;
            cnt_reg    <= cnt_next;
            ebit_reg   <= ebit_next;
            fidx_reg   <= fidx_next;
            inner_reg  <= inner_next;
            ret_reg    <= ret_next;
            phase_reg  <= phase_next;
            mulb_reg   <= mulb_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        m_reg <= m_next; phi_reg <= phi_next; n_reg <= n_next; k_reg <= k_next;
        q_reg <= q_next; rm_reg <= rm_next; dv_reg <= dv_next;
        acc_reg <= acc_next; ma_reg <= ma_next; mb_reg <= mb_next;
        pow_reg <= pow_next; base_reg <= base_next; e_reg <= e_next;
        cand_reg <= cand_next;
        res_root_reg <= res_root_next; res_found_reg <= res_found_next;
        root_reg <= root_next; found_reg <= found_next;
    end

    // Factor store. The read port follows the factor index, so the entry in use
    // is in the read register from the cycle after the index is set.
    always_ff @(posedge clk)
    begin
        if (fac_we)
            fac_mem[fcnt_reg[FIW-1:0]] <= fac_wdata;
        fac_rd_reg <= fac_mem[fidx_next];
    end

`ifndef SYNTH
    a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCW'(MAX_FACTORS))
        else $error("factor count beyond store depth");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (alu_b != '0))
        else $error("division by zero in shared unit");
    a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !found_reg) |-> (root_reg == '0))
        else $error("root not zero without found");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && ovalid_reg && !m_axis_tready) |=> (state_reg == S_OUT))
        else $error("result dropped while receiver stalls");
`endif

endmodule
